// ===== sv/gscg_pkg.sv =====
// Package for the gimbal servo command gate.
// Register indexes, reset values, servo offsets and the per-axis result type.
// No dependencies.
`default_nettype none

package gscg_pkg;

   localparam int AngleWidth  = 17;
   localparam int TargetWidth = 18;
   localparam int CsrIdxWidth = 3;

   localparam logic [CsrIdxWidth-1:0] CSR_YAW_LOW    = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_YAW_HIGH   = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_PITCH_LOW  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_PITCH_HIGH = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_IDLE_LIMIT = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_PERIOD     = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CSR_DEADBAND   = 3'd6;
   localparam logic [CsrIdxWidth-1:0] CSR_PRESENCE   = 3'd7;

   localparam logic signed [AngleWidth-1:0] YAW_LOW_RESET    = -17'sd12000;
   localparam logic signed [AngleWidth-1:0] YAW_HIGH_RESET   = 17'sd12000;
   localparam logic signed [AngleWidth-1:0] PITCH_LOW_RESET  = -17'sd9000;
   localparam logic signed [AngleWidth-1:0] PITCH_HIGH_RESET = 17'sd9000;
   localparam logic [15:0]                  IDLE_LIMIT_RESET = 16'd100;
   localparam logic [15:0]                  PERIOD_RESET     = 16'd20;
   localparam logic [15:0]                  DEADBAND_RESET   = 16'd10;
   localparam logic [2:0]                   PRESENCE_RESET   = 3'd7;

   // servo zero sits at 120 and 90 degrees of the gimbal frame
   localparam logic signed [TargetWidth-1:0] YAW_OFFSET   = 18'sd12000;
   localparam logic signed [TargetWidth-1:0] PITCH_OFFSET = 18'sd9000;

   typedef struct packed {
      logic signed [AngleWidth-1:0]  angle;
      logic signed [TargetWidth-1:0] target;
      logic                          needs_move;
   } axis_result_type;

endpackage

`default_nettype wire

// ===== sv/gscg_axis.sv =====
// One gimbal axis: clamped angle update, servo target and deadband check.
// Depends on gscg_pkg.
`default_nettype none

module gscg_axis (
   input  wire logic                                    apply,
   input  wire logic signed [gscg_pkg::AngleWidth-1:0]  angle,
   input  wire logic signed [gscg_pkg::AngleWidth-1:0]  delta,
   input  wire logic signed [gscg_pkg::AngleWidth-1:0]  low_limit,
   input  wire logic signed [gscg_pkg::AngleWidth-1:0]  high_limit,
   input  wire logic signed [gscg_pkg::TargetWidth-1:0] offset,
   input  wire logic signed [gscg_pkg::TargetWidth-1:0] last_target,
   input  wire logic                                    sent,
   input  wire logic [15:0]                             deadband,
   output gscg_pkg::axis_result_type                    result
);

   logic signed [gscg_pkg::TargetWidth-1:0] sum;
   logic signed [gscg_pkg::TargetWidth-1:0] low_ext;
   logic signed [gscg_pkg::TargetWidth-1:0] high_ext;
   logic signed [gscg_pkg::AngleWidth-1:0]  clamped;
   logic signed [gscg_pkg::AngleWidth-1:0]  angle_next;
   logic signed [gscg_pkg::TargetWidth-1:0] target;
   logic signed [gscg_pkg::TargetWidth:0]   diff;
   logic [gscg_pkg::TargetWidth:0]          mag;

   always_comb begin
      sum      = {angle[gscg_pkg::AngleWidth-1], angle} + {delta[gscg_pkg::AngleWidth-1], delta};
      low_ext  = {low_limit[gscg_pkg::AngleWidth-1], low_limit};
      high_ext = {high_limit[gscg_pkg::AngleWidth-1], high_limit};
      if (sum < low_ext) begin
         clamped = low_limit;
      end else if (sum > high_ext) begin
         clamped = high_limit;
      end else begin
         clamped = sum[gscg_pkg::AngleWidth-1:0];
      end
      angle_next = apply ? clamped : angle;
      target     = {angle_next[gscg_pkg::AngleWidth-1], angle_next} + offset;
      diff       = {target[gscg_pkg::TargetWidth-1], target}
                 - {last_target[gscg_pkg::TargetWidth-1], last_target};
      mag        = diff[gscg_pkg::TargetWidth] ? 19'(-diff) : 19'(diff);
      result.angle      = angle_next;
      result.target     = target;
      result.needs_move = !sent || (mag >= {3'b000, deadband});
   end

endmodule

`default_nettype wire

// ===== sv/gimbal_servo_command_gate.sv =====
// Top level of the gimbal servo command gate: registers, tick handshake and stop/move decision.
// Depends on gscg_pkg and gscg_axis.
//
//   channel  prefix  direction  handshake       contents
//   tick     req_    in         valid / ready   command, deltas, time in ms
//   result   rsp_    out        valid / ready   stop/move flags, targets, angles, sequence
//   config   csr_    in         write enable    index and data, no read-back
//
// One tick per cycle sustained while rsp_ready is high; rsp_valid rises as a tick leaves the input register.
// A tick sits in the input register, is evaluated in one pass against the state
// registers and moves into the result register as the state registers update.
// A stalled result holds the input register; req_ready stays high while either side has room.
// Synchronous reset restores register reset values and clears the state registers and valid flags.
`default_nettype none

module gimbal_servo_command_gate (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output      logic                                   req_ready,
   input  wire logic                                   req_cmd_valid,
   input  wire logic                                   req_cmd_enable,
   input  wire logic signed [gscg_pkg::AngleWidth-1:0] req_yaw_delta,
   input  wire logic signed [gscg_pkg::AngleWidth-1:0] req_pitch_delta,
   input  wire logic [31:0]                            req_now_ms,
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_ready,
   output      logic                                   rsp_stop_yaw,
   output      logic                                   rsp_stop_pitch,
   output      logic                                   rsp_move_yaw,
   output      logic                                   rsp_move_pitch,
   output      logic signed [gscg_pkg::AngleWidth-1:0] rsp_yaw_servo_target,
   output      logic signed [gscg_pkg::AngleWidth-1:0] rsp_pitch_servo_target,
   output      logic signed [gscg_pkg::AngleWidth-1:0] rsp_yaw_now,
   output      logic signed [gscg_pkg::AngleWidth-1:0] rsp_pitch_now,
   output      logic                                   rsp_link_ready,
   output      logic [31:0]                            rsp_tick_sequence,
   input  wire logic                                   csr_wr_en,
   input  wire logic [gscg_pkg::CsrIdxWidth-1:0]       csr_index,
   input  wire logic [gscg_pkg::AngleWidth-1:0]        csr_wdata
);

   // configuration
   logic signed [gscg_pkg::AngleWidth-1:0] yaw_low_ff, yaw_high_ff;
   logic signed [gscg_pkg::AngleWidth-1:0] pitch_low_ff, pitch_high_ff;
   logic [15:0] idle_limit_ff, period_ff, deadband_ff;
   logic [2:0]  presence_ff;

   // input register
   logic                                   in_valid_ff, in_valid_in;
   logic                                   in_cmd_valid_ff, in_cmd_enable_ff;
   logic signed [gscg_pkg::AngleWidth-1:0] in_yaw_delta_ff, in_pitch_delta_ff;
   logic [31:0]                            in_now_ff;

   // state
   logic signed [gscg_pkg::AngleWidth-1:0]  yaw_angle_ff, pitch_angle_ff;
   logic                                    motion_ff, motion_in;
   logic [15:0]                             idle_ff, idle_in, idle_inc;
   logic                                    stopped_ff, stopped_in;
   logic signed [gscg_pkg::TargetWidth-1:0] yaw_last_ff, yaw_last_in;
   logic signed [gscg_pkg::TargetWidth-1:0] pitch_last_ff, pitch_last_in;
   logic                                    yaw_sent_ff, yaw_sent_in;
   logic                                    pitch_sent_ff, pitch_sent_in;
   logic [31:0]                             next_upd_ff, next_upd_in;
   logic [31:0]                             report_ff, report_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in;

   logic fire, apply, link, yaw_on, pitch_on, due, do_stop;
   logic stop_y, stop_p, move_y, move_p;
   gscg_pkg::axis_result_type yaw_res, pitch_res;

   assign fire         = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || fire;
   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign rsp_valid    = rsp_valid_ff;

   assign apply    = in_cmd_valid_ff && in_cmd_enable_ff;
   assign link     = presence_ff[0];
   assign yaw_on   = presence_ff[1];
   assign pitch_on = presence_ff[2];

   gscg_axis u_yaw (
      .apply       (apply),
      .angle       (yaw_angle_ff),
      .delta       (in_yaw_delta_ff),
      .low_limit   (yaw_low_ff),
      .high_limit  (yaw_high_ff),
      .offset      (gscg_pkg::YAW_OFFSET),
      .last_target (yaw_last_ff),
      .sent        (yaw_sent_ff),
      .deadband    (deadband_ff),
      .result      (yaw_res)
   );

   gscg_axis u_pitch (
      .apply       (apply),
      .angle       (pitch_angle_ff),
      .delta       (in_pitch_delta_ff),
      .low_limit   (pitch_low_ff),
      .high_limit  (pitch_high_ff),
      .offset      (gscg_pkg::PITCH_OFFSET),
      .last_target (pitch_last_ff),
      .sent        (pitch_sent_ff),
      .deadband    (deadband_ff),
      .result      (pitch_res)
   );

   always_comb begin
      idle_inc = (idle_ff != 16'hFFFF) ? idle_ff + 16'd1 : idle_ff;
      if (in_cmd_valid_ff) begin
         idle_in   = '0;
         motion_in = in_cmd_enable_ff;
      end else begin
         idle_in   = idle_inc;
         motion_in = (idle_inc > idle_limit_ff) ? 1'b0 : motion_ff;
      end

      due     = in_now_ff >= next_upd_ff;
      do_stop = link && !motion_in && !stopped_ff;
      stop_y  = do_stop && yaw_on;
      stop_p  = do_stop && pitch_on;
      move_y  = link && motion_in && due && yaw_on && yaw_res.needs_move;
      move_p  = link && motion_in && due && pitch_on && pitch_res.needs_move;

      stopped_in    = link ? !motion_in : stopped_ff;
      yaw_sent_in   = do_stop ? 1'b0 : (move_y ? 1'b1 : yaw_sent_ff);
      pitch_sent_in = do_stop ? 1'b0 : (move_p ? 1'b1 : pitch_sent_ff);
      yaw_last_in   = move_y ? yaw_res.target : yaw_last_ff;
      pitch_last_in = move_p ? pitch_res.target : pitch_last_ff;
      next_upd_in   = (link && motion_in && due) ? in_now_ff + {16'd0, period_ff}
                                                 : next_upd_ff;
      report_in     = report_ff + 32'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_low_ff    <= gscg_pkg::YAW_LOW_RESET;
         yaw_high_ff   <= gscg_pkg::YAW_HIGH_RESET;
         pitch_low_ff  <= gscg_pkg::PITCH_LOW_RESET;
         pitch_high_ff <= gscg_pkg::PITCH_HIGH_RESET;
         idle_limit_ff <= gscg_pkg::IDLE_LIMIT_RESET;
         period_ff     <= gscg_pkg::PERIOD_RESET;
         deadband_ff   <= gscg_pkg::DEADBAND_RESET;
         presence_ff   <= gscg_pkg::PRESENCE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            gscg_pkg::CSR_YAW_LOW:    yaw_low_ff    <= csr_wdata;
            gscg_pkg::CSR_YAW_HIGH:   yaw_high_ff   <= csr_wdata;
            gscg_pkg::CSR_PITCH_LOW:  pitch_low_ff  <= csr_wdata;
            gscg_pkg::CSR_PITCH_HIGH: pitch_high_ff <= csr_wdata;
            gscg_pkg::CSR_IDLE_LIMIT: idle_limit_ff <= csr_wdata[15:0];
            gscg_pkg::CSR_PERIOD:     period_ff     <= csr_wdata[15:0];
            gscg_pkg::CSR_DEADBAND:   deadband_ff   <= csr_wdata[15:0];
            gscg_pkg::CSR_PRESENCE:   presence_ff   <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_cmd_valid_ff   <= req_cmd_valid;
         in_cmd_enable_ff  <= req_cmd_enable;
         in_yaw_delta_ff   <= req_yaw_delta;
         in_pitch_delta_ff <= req_pitch_delta;
         in_now_ff         <= req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_angle_ff   <= '0;
         pitch_angle_ff <= '0;
         motion_ff      <= 1'b0;
         idle_ff        <= '0;
         stopped_ff     <= 1'b0;
         yaw_last_ff    <= '0;
         pitch_last_ff  <= '0;
         yaw_sent_ff    <= 1'b0;
         pitch_sent_ff  <= 1'b0;
         next_upd_ff    <= '0;
         report_ff      <= '0;
      end else if (fire) begin
         yaw_angle_ff   <= yaw_res.angle;
         pitch_angle_ff <= pitch_res.angle;
         motion_ff      <= motion_in;
         idle_ff        <= idle_in;
         stopped_ff     <= stopped_in;
         yaw_last_ff    <= yaw_last_in;
         pitch_last_ff  <= pitch_last_in;
         yaw_sent_ff    <= yaw_sent_in;
         pitch_sent_ff  <= pitch_sent_in;
         next_upd_ff    <= next_upd_in;
         report_ff      <= report_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_stop_yaw           <= stop_y;
         rsp_stop_pitch         <= stop_p;
         rsp_move_yaw           <= move_y;
         rsp_move_pitch         <= move_p;
         rsp_yaw_servo_target   <= yaw_res.target[gscg_pkg::AngleWidth-1:0];
         rsp_pitch_servo_target <= pitch_res.target[gscg_pkg::AngleWidth-1:0];
         rsp_yaw_now            <= yaw_res.angle;
         rsp_pitch_now          <= pitch_res.angle;
         rsp_link_ready         <= link;
         rsp_tick_sequence      <= report_in;
      end
   end

endmodule

`default_nettype wire
